### design/cprt_pkg.sv
`default_nettype none
package cprt_pkg;

  localparam int unsigned LEN_W        = 16;
  localparam int unsigned NP_W         = 5;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned OUT_IDX_W    = 4;
  localparam int unsigned MIN_PERIODS  = 3;
  localparam logic [LEN_W-1:0] LEN_RESET = 16'd4096;
  localparam logic [NP_W-1:0]  NP_RESET  = 5'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PERIODS   = 1'd1;

  typedef enum logic [1:0] {
    OP_DONE    = 2'd0,
    OP_CONSUME = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_RESET   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NOT_FILLED = 2'd1,
    STAT_OVERRUN    = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    ST_FILLED   = 2'd0,
    ST_CONSUMED = 2'd1,
    ST_DMA      = 2'd2
  } pst_t;

  typedef enum logic [1:0] {
    ALU_ADD      = 2'd0,
    ALU_SUB      = 2'd1,
    ALU_INC_WRAP = 2'd2
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_D_ADV,
    S_D_NXT,
    S_D_CHK,
    S_C_RD,
    S_C_LEFT,
    S_C_MIN,
    S_C_ADD,
    S_C_WRAP,
    S_F_WALK,
    S_R_CLR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic st_we;
    logic off_we;
    logic clr;
  } ring_ctl_t;

endpackage
`default_nettype wire

### design/cyclic_period_ring_tracker_unit.sv
// Cyclic period ring tracker: follows a ring of receive periods (filled,
// consumed or DMA owned, each with a read offset), a reader head and a
// writer tail.
// Command channel: an opcode and request_bytes are taken at a clock edge
// with start high and busy low; busy stays high while the item is worked.
// Result channel: out_valid is high for exactly one cycle with the status,
// grant, read position and both indices; the receiver cannot stall it.
// Configuration: cfg_we with cfg_index (0 period_length, 1 num_periods)
// writes cfg_wdata at once; write only while busy is low.
// Steps: period done advances the tail, then reads and checks the next
// period; consume reads the head and, if filled, takes the grant, moves
// the offset and wraps an emptied head; reset ring clears; flush marks
// one period per cycle. Busy is low again in the out_valid cycle, so a
// new transaction can follow at once. Offsets, lengths and indices go
// through one shared add/subtract/compare unit and one store read port.
// Reset: period_length 4096, num_periods 3, both indices 0, every period
// DMA owned with offset 0; per-entry valid bits clear the store at once,
// so no clearing pass is needed.
`default_nettype none
module cyclic_period_ring_tracker_unit
  import cprt_pkg::*;
#(
  parameter int unsigned MAX_PERIODS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_opcode,
  input  logic [LEN_W-1:0]     in_request_bytes,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [LEN_W-1:0]     out_granted_bytes,
  output logic [OUT_IDX_W-1:0] out_read_period,
  output logic [LEN_W-1:0]     out_read_offset,
  output logic                 out_period_emptied,
  output logic [OUT_IDX_W-1:0] out_head_index,
  output logic [OUT_IDX_W-1:0] out_tail_index
);

  localparam int unsigned IDX_W = $clog2(MAX_PERIODS);
  localparam int unsigned KW    = $clog2(MAX_PERIODS + 1);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [NP_W-1:0]  np_r, np_nxt;
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] eff_cnt;
  logic [LEN_W-1:0] np_ext;
  ring_ctl_t        ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] st_wa;
  pst_t             st_wd;
  logic [IDX_W-1:0] off_wa;
  logic [LEN_W-1:0] off_wd;
  pst_t             st_q;
  logic [LEN_W-1:0] off_q;
  stat_t            status;
  logic [IDX_W-1:0] rperiod;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;

  always_comb begin
    len_nxt = len_r;
    np_nxt  = np_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD_LENGTH: len_nxt = cfg_wdata;
        CFG_NUM_PERIODS:   np_nxt  = cfg_wdata[NP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
      np_r  <= NP_RESET;
    end else begin
      len_r <= len_nxt;
      np_r  <= np_nxt;
    end
  end

  assign np_ext  = LEN_W'(np_r);
  assign eff_len = (len_r == '0) ? LEN_W'(1) : len_r;

  always_comb begin
    if (np_ext < LEN_W'(MIN_PERIODS)) begin
      eff_cnt = LEN_W'(MIN_PERIODS);
    end else if (np_ext > LEN_W'(MAX_PERIODS)) begin
      eff_cnt = LEN_W'(MAX_PERIODS);
    end else begin
      eff_cnt = np_ext;
    end
  end

  cprt_seq #(
    .MAX_PERIODS (MAX_PERIODS),
    .IDX_W       (IDX_W),
    .KW          (KW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .op          (op_t'(in_opcode)),
    .req         (in_request_bytes),
    .len         (eff_len),
    .cnt         (eff_cnt),
    .busy        (busy),
    .ctl         (ctl),
    .rd_addr     (rd_addr),
    .st_wa       (st_wa),
    .st_wd       (st_wd),
    .off_wa      (off_wa),
    .off_wd      (off_wd),
    .st_q        (st_q),
    .off_q       (off_q),
    .out_valid   (out_valid),
    .out_status  (status),
    .out_granted (out_granted_bytes),
    .out_rperiod (rperiod),
    .out_roffset (out_read_offset),
    .out_emptied (out_period_emptied),
    .out_head    (head),
    .out_tail    (tail)
  );

  cprt_ring #(
    .MAX_PERIODS (MAX_PERIODS),
    .IDX_W       (IDX_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .st_wa   (st_wa),
    .st_wd   (st_wd),
    .off_wa  (off_wa),
    .off_wd  (off_wd),
    .st_q    (st_q),
    .off_q   (off_q)
  );

  assign out_status      = status;
  assign out_read_period = OUT_IDX_W'(rperiod);
  assign out_head_index  = OUT_IDX_W'(head);
  assign out_tail_index  = OUT_IDX_W'(tail);

endmodule
`default_nettype wire

### design/cprt_alu.sv
`default_nettype none
module cprt_alu
  import cprt_pkg::*;
(
  input  alu_op_t          op,
  input  logic [LEN_W-1:0] a,
  input  logic [LEN_W-1:0] b,
  output logic [LEN_W:0]   res
);

  logic [LEN_W:0] inc;

  assign inc = {1'b0, a} + {{LEN_W{1'b0}}, 1'b1};

  always_comb begin
    unique case (op)
      ALU_ADD:      res = {1'b0, a} + {1'b0, b};
      ALU_SUB:      res = {1'b0, a} - {1'b0, b};
      ALU_INC_WRAP: res = (inc >= {1'b0, b}) ? '0 : inc;
      default:      res = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/cprt_ring.sv
`default_nettype none
module cprt_ring
  import cprt_pkg::*;
#(
  parameter int unsigned MAX_PERIODS = 16,
  parameter int unsigned IDX_W       = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ring_ctl_t        ctl,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic [IDX_W-1:0] st_wa,
  input  pst_t             st_wd,
  input  logic [IDX_W-1:0] off_wa,
  input  logic [LEN_W-1:0] off_wd,
  output pst_t             st_q,
  output logic [LEN_W-1:0] off_q
);

  pst_t                   st_mem  [MAX_PERIODS];
  logic [LEN_W-1:0]       off_mem [MAX_PERIODS];
  logic [MAX_PERIODS-1:0] st_vld_r;
  logic [MAX_PERIODS-1:0] off_vld_r;
  pst_t                   st_rd_r;
  logic [LEN_W-1:0]       off_rd_r;
  logic                   st_v_rd_r;
  logic                   off_v_rd_r;

  always_ff @(posedge clk) begin
    if (ctl.st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    if (ctl.off_we) begin
      off_mem[off_wa] <= off_wd;
    end
    st_rd_r    <= st_mem[rd_addr];
    off_rd_r   <= off_mem[rd_addr];
    st_v_rd_r  <= st_vld_r[rd_addr];
    off_v_rd_r <= off_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r  <= '0;
      off_vld_r <= '0;
    end else if (ctl.clr) begin
      st_vld_r  <= '0;
      off_vld_r <= '0;
    end else begin
      if (ctl.st_we) begin
        st_vld_r[st_wa] <= 1'b1;
      end
      if (ctl.off_we) begin
        off_vld_r[off_wa] <= 1'b1;
      end
    end
  end

  assign st_q  = st_v_rd_r ? st_rd_r : ST_DMA;
  assign off_q = off_v_rd_r ? off_rd_r : '0;

endmodule
`default_nettype wire

### design/cprt_seq.sv
`default_nettype none
module cprt_seq
  import cprt_pkg::*;
#(
  parameter int unsigned MAX_PERIODS = 16,
  parameter int unsigned IDX_W       = 4,
  parameter int unsigned KW          = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  op_t                  op,
  input  logic [LEN_W-1:0]     req,
  input  logic [LEN_W-1:0]     len,
  input  logic [LEN_W-1:0]     cnt,
  output logic                 busy,
  output ring_ctl_t            ctl,
  output logic [IDX_W-1:0]     rd_addr,
  output logic [IDX_W-1:0]     st_wa,
  output pst_t                 st_wd,
  output logic [IDX_W-1:0]     off_wa,
  output logic [LEN_W-1:0]     off_wd,
  input  pst_t                 st_q,
  input  logic [LEN_W-1:0]     off_q,
  output logic                 out_valid,
  output stat_t                out_status,
  output logic [LEN_W-1:0]     out_granted,
  output logic [IDX_W-1:0]     out_rperiod,
  output logic [LEN_W-1:0]     out_roffset,
  output logic                 out_emptied,
  output logic [IDX_W-1:0]     out_head,
  output logic [IDX_W-1:0]     out_tail
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] r_r, r_nxt;
  logic [IDX_W-1:0] w_r, w_nxt;
  logic [IDX_W-1:0] d_r, d_nxt;
  logic [LEN_W-1:0] req_r, req_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [LEN_W-1:0] gr_r, gr_nxt;
  logic             emp_r, emp_nxt;
  stat_t            stat_r, stat_nxt;
  logic [IDX_W-1:0] rp_r, rp_nxt;
  logic [LEN_W-1:0] ro_r, ro_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             out_valid_r;
  stat_t            out_status_r;
  logic [LEN_W-1:0] out_granted_r;
  logic [IDX_W-1:0] out_rperiod_r;
  logic [LEN_W-1:0] out_roffset_r;
  logic             out_emptied_r;
  logic [IDX_W-1:0] out_head_r;
  logic [IDX_W-1:0] out_tail_r;
  alu_op_t          alu_op;
  logic [LEN_W-1:0] alu_a;
  logic [LEN_W-1:0] alu_b;
  logic [LEN_W:0]   alu_res;
  logic             flush_end;

  cprt_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign flush_end = (k_r == KW'(MAX_PERIODS)) || (r_r == w_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (op)
            OP_DONE:    state_nxt = S_D_ADV;
            OP_CONSUME: state_nxt = S_C_RD;
            OP_FLUSH:   state_nxt = S_F_WALK;
            OP_RESET:   state_nxt = S_R_CLR;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_D_ADV:  state_nxt = S_D_NXT;
      S_D_NXT:  state_nxt = S_D_CHK;
      S_D_CHK:  state_nxt = S_RESP;
      S_C_RD:   state_nxt = S_C_LEFT;
      S_C_LEFT: state_nxt = (st_q != ST_FILLED) ? S_RESP : S_C_MIN;
      S_C_MIN:  state_nxt = S_C_ADD;
      S_C_ADD:  state_nxt = emp_r ? S_C_WRAP : S_RESP;
      S_C_WRAP: state_nxt = S_RESP;
      S_F_WALK: state_nxt = flush_end ? S_RESP : S_F_WALK;
      S_R_CLR:  state_nxt = S_RESP;
      S_RESP:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    r_nxt    = r_r;
    w_nxt    = w_r;
    d_nxt    = d_r;
    req_nxt  = req_r;
    pos_nxt  = pos_r;
    left_nxt = left_r;
    gr_nxt   = gr_r;
    emp_nxt  = emp_r;
    stat_nxt = stat_r;
    rp_nxt   = rp_r;
    ro_nxt   = ro_r;
    k_nxt    = k_r;
    alu_op   = ALU_INC_WRAP;
    alu_a    = LEN_W'(r_r);
    alu_b    = cnt;
    ctl      = '0;
    rd_addr  = r_r;
    st_wa    = r_r;
    st_wd    = ST_CONSUMED;
    off_wa   = r_r;
    off_wd   = '0;
    unique case (state_r)
      S_IDLE: begin
        req_nxt  = req;
        stat_nxt = STAT_OK;
        gr_nxt   = '0;
        emp_nxt  = 1'b0;
        rp_nxt   = '0;
        ro_nxt   = '0;
        k_nxt    = '0;
      end
      S_D_ADV: begin
        alu_a     = LEN_W'(w_r);
        ctl.st_we = 1'b1;
        st_wa     = w_r;
        st_wd     = ST_FILLED;
        w_nxt     = IDX_W'(alu_res);
      end
      S_D_NXT: begin
        alu_a   = LEN_W'(w_r);
        d_nxt   = IDX_W'(alu_res);
        rd_addr = IDX_W'(alu_res);
      end
      S_D_CHK: begin
        alu_a     = LEN_W'(d_r);
        rd_addr   = d_r;
        if (r_r == d_r) begin
          if (st_q == ST_FILLED) begin
            stat_nxt = STAT_OVERRUN;
          end
          r_nxt = IDX_W'(alu_res);
        end
        ctl.st_we = 1'b1;
        st_wa     = d_r;
        st_wd     = ST_DMA;
        if (st_q != ST_DMA) begin
          ctl.off_we = 1'b1;
          off_wa     = d_r;
          off_wd     = '0;
        end
      end
      S_C_RD: begin
      end
      S_C_LEFT: begin
        alu_op  = ALU_SUB;
        alu_a   = len;
        alu_b   = off_q;
        rp_nxt  = r_r;
        ro_nxt  = off_q;
        pos_nxt = off_q;
        if (st_q != ST_FILLED) begin
          stat_nxt = STAT_NOT_FILLED;
        end
        left_nxt = alu_res[LEN_W] ? '0 : alu_res[LEN_W-1:0];
      end
      S_C_MIN: begin
        alu_op = ALU_SUB;
        alu_a  = req_r;
        alu_b  = left_r;
        if (alu_res[LEN_W]) begin
          gr_nxt  = req_r;
          emp_nxt = 1'b0;
        end else begin
          gr_nxt  = left_r;
          emp_nxt = 1'b1;
        end
      end
      S_C_ADD: begin
        alu_op     = ALU_ADD;
        alu_a      = pos_r;
        alu_b      = gr_r;
        ctl.off_we = 1'b1;
        off_wd     = alu_res[LEN_W-1:0];
        ctl.st_we  = emp_r;
        st_wd      = ST_CONSUMED;
      end
      S_C_WRAP: begin
        r_nxt = IDX_W'(alu_res);
      end
      S_F_WALK: begin
        if (!flush_end) begin
          ctl.st_we = 1'b1;
          st_wd     = ST_CONSUMED;
          r_nxt     = IDX_W'(alu_res);
          k_nxt     = k_r + KW'(1);
        end
      end
      S_R_CLR: begin
        ctl.clr = 1'b1;
        r_nxt   = '0;
        w_nxt   = '0;
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      r_r         <= '0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      r_r         <= r_nxt;
      w_r         <= w_nxt;
      out_valid_r <= (state_r == S_RESP);
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    req_r  <= req_nxt;
    pos_r  <= pos_nxt;
    left_r <= left_nxt;
    gr_r   <= gr_nxt;
    emp_r  <= emp_nxt;
    stat_r <= stat_nxt;
    rp_r   <= rp_nxt;
    ro_r   <= ro_nxt;
    k_r    <= k_nxt;
    if (state_r == S_RESP) begin
      out_status_r  <= stat_r;
      out_granted_r <= gr_r;
      out_rperiod_r <= rp_r;
      out_roffset_r <= ro_r;
      out_emptied_r <= emp_r;
      out_head_r    <= r_r;
      out_tail_r    <= w_r;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_granted = out_granted_r;
  assign out_rperiod = out_rperiod_r;
  assign out_roffset = out_roffset_r;
  assign out_emptied = out_emptied_r;
  assign out_head    = out_head_r;
  assign out_tail    = out_tail_r;

endmodule
`default_nettype wire

### design/cprt_checker.sv
`default_nettype none
module cprt_checker
  import cprt_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [1:0]       out_status,
  input logic [LEN_W-1:0] out_granted_bytes,
  input logic             out_period_emptied
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy dropped without a result");

  a_not_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_NOT_FILLED)) |->
      ((out_granted_bytes == '0) && !out_period_emptied))
    else $error("grant on a period that is not filled");

  a_emptied_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_period_emptied) |-> (out_status == STAT_OK))
    else $error("period emptied with bad status");

endmodule

bind cyclic_period_ring_tracker_unit cprt_checker u_cprt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_status         (out_status),
  .out_granted_bytes  (out_granted_bytes),
  .out_period_emptied (out_period_emptied)
);
`default_nettype wire
